/* rtl/setc_pkg.sv */
// ----------------------------------------------------------------------------
// Scope edge trigger capture package
// Shared constants, codes and types for the capture block.
// ----------------------------------------------------------------------------
`default_nettype none

package setc_pkg;

   localparam int BUFFER_DEPTH_DEF = 2048;
   localparam int WINDOW_DEF       = 256;
   localparam int FRAME_MARGIN     = 10;

   localparam logic [10:0] PRETRIG_RESET = 11'd256;

   localparam logic [1:0] REQ_SAMPLE = 2'd0;
   localparam logic [1:0] REQ_FRAME  = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;
   localparam logic [1:0] REQ_READ   = 2'd3;

   localparam logic [1:0] MODE_AUTO   = 2'd0;
   localparam logic [1:0] MODE_NORMAL = 2'd1;
   localparam logic [1:0] MODE_SINGLE = 2'd2;

   localparam logic EDGE_RISING = 1'b0;

   localparam logic [1:0] CSR_TRIG_MODE  = 2'd0;
   localparam logic [1:0] CSR_TRIG_EDGE  = 2'd1;
   localparam logic [1:0] CSR_TRIG_LEVEL = 2'd2;
   localparam logic [1:0] CSR_PRETRIG    = 2'd3;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } setc_state_type;

   typedef struct packed {
      logic        window_valid;
      logic        triggered;
      logic [10:0] window_start;
      logic [10:0] trigger_index;
   } setc_status_type;

endpackage

`default_nettype wire

/* rtl/setc_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module setc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/setc_core.sv */
// ----------------------------------------------------------------------------
// Capture core
// Holds pointers, trigger state and settings, and drives the sample memory.
// ----------------------------------------------------------------------------
`default_nettype none

module setc_core #(
   parameter int BUFFER_DEPTH = setc_pkg::BUFFER_DEPTH_DEF,
   parameter int WINDOW       = setc_pkg::WINDOW_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [1:0]                      csr_index,
   input  wire logic [15:0]                     csr_wr_data,
   input  wire logic                            item_go,
   input  wire logic [1:0]                      req_type,
   input  wire logic signed [15:0]              req_ch1_sample,
   input  wire logic signed [15:0]              req_ch2_sample,
   input  wire logic [7:0]                      req_read_offset,
   output logic                                 ram_wr_en,
   output logic [$clog2(BUFFER_DEPTH)-1:0]      ram_wr_addr,
   output logic [31:0]                          ram_wr_data,
   output logic                                 ram_rd_en,
   output logic [$clog2(BUFFER_DEPTH)-1:0]      ram_rd_addr,
   output logic                                 rd_hit,
   output setc_pkg::setc_status_type            status
);

   import setc_pkg::*;

   localparam int AW   = $clog2(BUFFER_DEPTH);
   localparam int AW1  = AW + 1;
   localparam int FW   = $clog2(BUFFER_DEPTH + 1);
   localparam int CW   = (AW > 11) ? AW : 11;
   localparam int WMOD = WINDOW % BUFFER_DEPTH;

   localparam logic [AW-1:0]  WP_LAST   = AW'(BUFFER_DEPTH - 1);
   localparam logic [AW1-1:0] DEPTH_X   = AW1'(BUFFER_DEPTH);
   localparam logic [AW1-1:0] AUTO_ADD  = AW1'(BUFFER_DEPTH - WMOD);
   localparam logic [FW-1:0]  FILL_MAX  = FW'(BUFFER_DEPTH);
   localparam logic [31:0]    FRAME_MIN = 32'(WINDOW + FRAME_MARGIN);

   logic [1:0]         mode_ff, mode_in;
   logic               trig_edge_ff, trig_edge_in;
   logic signed [15:0] level_ff, level_in;
   logic [10:0]        pre_ff, pre_in;

   logic [AW-1:0]      wp_ff, wp_in;
   logic [FW-1:0]      fill_ff, fill_in;
   logic signed [15:0] prev_ff, prev_in;
   logic               trig_ff, trig_in;
   logic [AW-1:0]      trig_pos_ff, trig_pos_in;
   logic [AW-1:0]      win_ff, win_in;
   logic               ready_ff, ready_in;

   logic signed [15:0] prev_eff;
   logic               hit;
   logic               forced;
   logic [FW-1:0]      fill_inc;
   logic [CW-1:0]      tp_ext;
   logic [CW-1:0]      pre_ext;
   logic [AW1-1:0]     auto_sum;
   logic [AW-1:0]      auto_win;
   logic [AW1-1:0]     rd_sum;
   logic [AW-1:0]      rd_pos;
   logic [CW-1:0]      win_out;
   logic [CW-1:0]      tp_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_AUTO;
         trig_edge_ff <= EDGE_RISING;
         level_ff     <= '0;
         pre_ff       <= PRETRIG_RESET;
         wp_ff        <= '0;
         fill_ff      <= '0;
         prev_ff      <= '0;
         trig_ff      <= 1'b0;
         trig_pos_ff  <= '0;
         win_ff       <= '0;
         ready_ff     <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         trig_edge_ff <= trig_edge_in;
         level_ff     <= level_in;
         pre_ff       <= pre_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         prev_ff      <= prev_in;
         trig_ff      <= trig_in;
         trig_pos_ff  <= trig_pos_in;
         win_ff       <= win_in;
         ready_ff     <= ready_in;
      end
   end

   always_comb begin
      prev_eff = (fill_ff != '0) ? prev_ff : req_ch1_sample;
      if (trig_edge_ff == EDGE_RISING) begin
         hit = (prev_eff < level_ff) && (req_ch1_sample >= level_ff);
      end else begin
         hit = (prev_eff > level_ff) && (req_ch1_sample <= level_ff);
      end
      fill_inc = (fill_ff < FILL_MAX) ? fill_ff + 1'b1 : fill_ff;
      forced   = (mode_ff == MODE_AUTO) && (fill_inc == FILL_MAX);

      tp_ext  = CW'(trig_pos_ff);
      pre_ext = CW'(pre_ff);

      auto_sum = AW1'(wp_ff) + AUTO_ADD;
      auto_win = (auto_sum >= DEPTH_X) ? AW'(auto_sum - DEPTH_X) : AW'(auto_sum);

      rd_sum = AW1'(win_ff) + AW1'(req_read_offset);
      rd_pos = (rd_sum >= DEPTH_X) ? AW'(rd_sum - DEPTH_X) : AW'(rd_sum);
   end

   always_comb begin
      mode_in      = mode_ff;
      trig_edge_in = trig_edge_ff;
      level_in     = level_ff;
      pre_in       = pre_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      prev_in      = prev_ff;
      trig_in      = trig_ff;
      trig_pos_in  = trig_pos_ff;
      win_in       = win_ff;
      ready_in     = ready_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TRIG_MODE: begin
               mode_in = csr_wr_data[1:0];
               trig_in = 1'b0;
            end
            CSR_TRIG_EDGE:  trig_edge_in = csr_wr_data[0];
            CSR_TRIG_LEVEL: level_in     = csr_wr_data;
            CSR_PRETRIG:    pre_in       = csr_wr_data[10:0];
            default:        mode_in      = mode_ff;
         endcase
      end else if (item_go) begin
         unique case (req_type)
            REQ_SAMPLE: begin
               ram_wr_en = 1'b1;
               wp_in     = (wp_ff == WP_LAST) ? '0 : wp_ff + 1'b1;
               fill_in   = fill_inc;
               prev_in   = req_ch1_sample;
               ready_in  = 1'b0;
               if (!trig_ff && (hit || forced)) begin
                  trig_in     = 1'b1;
                  trig_pos_in = wp_ff;
               end
            end
            REQ_FRAME: begin
               priority if (32'(fill_ff) < FRAME_MIN) begin
                  ready_in = 1'b0;
               end else if (trig_ff) begin
                  win_in   = (tp_ext >= pre_ext) ? AW'(tp_ext - pre_ext) : '0;
                  ready_in = 1'b1;
                  if (mode_ff != MODE_SINGLE) begin
                     trig_in = 1'b0;
                  end
               end else if (mode_ff == MODE_AUTO) begin
                  win_in   = auto_win;
                  ready_in = 1'b1;
               end else begin
                  ready_in = ready_ff;
               end
            end
            REQ_CLEAR: begin
               wp_in    = '0;
               fill_in  = '0;
               win_in   = '0;
               ready_in = 1'b0;
               trig_in  = 1'b0;
               prev_in  = '0;
            end
            REQ_READ: begin
               ram_rd_en = 1'b1;
            end
            default: begin
               ram_rd_en = 1'b0;
            end
         endcase
      end
   end

   assign ram_wr_addr = wp_ff;
   assign ram_wr_data = {req_ch2_sample, req_ch1_sample};
   assign ram_rd_addr = rd_pos;

   // Entries at or beyond the fill count have not been written since the
   // last clear and read as zero.
   assign rd_hit = FW'(rd_pos) < fill_ff;

   assign win_out = CW'(win_in);
   assign tp_out  = CW'(trig_pos_in);

   always_comb begin
      status.window_valid  = ready_in;
      status.triggered     = trig_in;
      status.window_start  = win_out[10:0];
      status.trigger_index = tp_out[10:0];
   end

endmodule

`default_nettype wire

/* rtl/scope_edge_trigger_capture.sv */
// ----------------------------------------------------------------------------
// Scope edge trigger capture
// Two-channel capture into a ring buffer with an edge trigger on channel one.
// ----------------------------------------------------------------------------
// The req channel carries one command per beat: a sample pair, a frame
// request, a clear or a read of one window entry. Every request beat yields
// exactly one rsp beat with the flags, window start and trigger index as
// they stand after the command; the read fields carry data only for a read.
// Sample, frame and clear beats can be accepted on consecutive cycles
// while the receiver takes each rsp beat. A read passes through ST_READ,
// where the block waits for the registered read data of the sample memory
// and accepts no new request. The rsp register is one stage deep: when
// the receiver stalls, req_ready drops until the pending rsp beat is
// taken, so nothing is lost. Reset returns the settings to their defaults
// and empties the buffer at once; unwritten entries read as zero, tracked
// by the fill count, so no clearing pass is needed. The csr port writes
// one setting per cycle and should be used while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module scope_edge_trigger_capture #(
   parameter int BUFFER_DEPTH = setc_pkg::BUFFER_DEPTH_DEF,
   parameter int WINDOW       = setc_pkg::WINDOW_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_wr_data,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_type,
   input  wire logic signed [15:0] req_ch1_sample,
   input  wire logic signed [15:0] req_ch2_sample,
   input  wire logic [7:0]         req_read_offset,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_window_valid,
   output logic                    rsp_triggered,
   output logic [10:0]             rsp_window_start,
   output logic [10:0]             rsp_trigger_index,
   output logic signed [15:0]      rsp_read_ch1,
   output logic signed [15:0]      rsp_read_ch2
);

   import setc_pkg::*;

   localparam int AW = $clog2(BUFFER_DEPTH);

   setc_state_type  state_ff, state_in;
   logic            rsp_valid_ff, rsp_valid_in;
   setc_status_type status_ff;
   logic [15:0]     read_ch1_ff;
   logic [15:0]     read_ch2_ff;
   logic            rd_hit_ff;

   logic            accept;
   logic            load_item;
   logic            load_read;

   logic            ram_wr_en;
   logic [AW-1:0]   ram_wr_addr;
   logic [31:0]     ram_wr_data;
   logic            ram_rd_en;
   logic [AW-1:0]   ram_rd_addr;
   logic [31:0]     ram_rd_data;
   logic            rd_hit;
   setc_status_type status;

   setc_core #(
      .BUFFER_DEPTH(BUFFER_DEPTH),
      .WINDOW      (WINDOW)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .item_go        (accept),
      .req_type       (req_type),
      .req_ch1_sample (req_ch1_sample),
      .req_ch2_sample (req_ch2_sample),
      .req_read_offset(req_read_offset),
      .ram_wr_en      (ram_wr_en),
      .ram_wr_addr    (ram_wr_addr),
      .ram_wr_data    (ram_wr_data),
      .ram_rd_en      (ram_rd_en),
      .ram_rd_addr    (ram_rd_addr),
      .rd_hit         (rd_hit),
      .status         (status)
   );

   setc_ram #(
      .WIDTH(32),
      .DEPTH(BUFFER_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      load_item    = 1'b0;
      load_read    = 1'b0;
      accept       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            accept    = req_valid && req_ready;
            if (accept) begin
               if (req_type == REQ_READ) begin
                  state_in = ST_READ;
               end else begin
                  load_item = 1'b1;
               end
            end
         end
         ST_READ: begin
            load_read = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load_item || load_read) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_hit_ff <= rd_hit;
      end
      if (load_item) begin
         status_ff   <= status;
         read_ch1_ff <= '0;
         read_ch2_ff <= '0;
      end else if (load_read) begin
         status_ff   <= status;
         read_ch1_ff <= rd_hit_ff ? ram_rd_data[15:0] : '0;
         read_ch2_ff <= rd_hit_ff ? ram_rd_data[31:16] : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_window_valid  = status_ff.window_valid;
   assign rsp_triggered     = status_ff.triggered;
   assign rsp_window_start  = status_ff.window_start;
   assign rsp_trigger_index = status_ff.trigger_index;
   assign rsp_read_ch1      = read_ch1_ff;
   assign rsp_read_ch2      = read_ch2_ff;

endmodule

`default_nettype wire
